FILE: src/ogi_pkg.sv
// Shared types, constants and codes of the occupancy grid inflation unit.
`timescale 1ns / 1ps
package ogi_pkg;

   localparam int MAX_WIDTH_DEF    = 512;
   localparam int MAX_HEIGHT_DEF   = 512;
   localparam int MAX_RADIUS_DEF   = 15;
   localparam int SEARCH_LIMIT_DEF = 64;

   localparam logic [9:0] MAP_WIDTH_RST  = 10'd512;
   localparam logic [9:0] MAP_HEIGHT_RST = 10'd512;
   localparam logic [3:0] RADIUS_RST     = 4'd7;
   localparam logic [6:0] THRESHOLD_RST  = 7'd50;

   typedef enum logic [1:0] {
      CSR_MAP_WIDTH  = 2'd0,
      CSR_MAP_HEIGHT = 2'd1,
      CSR_RADIUS     = 2'd2,
      CSR_THRESHOLD  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_LOAD  = 2'd1,
      REQ_READ  = 2'd2,
      REQ_SNAP  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      RSP_ZERO,
      RSP_READ,
      RSP_SELF,
      RSP_BLOCKED,
      RSP_FOUND
   } rsp_kind_type;

   typedef enum logic [3:0] {
      ST_BOOT_CLR,
      ST_IDLE,
      ST_DISPATCH,
      ST_CLEAR,
      ST_LOAD,
      ST_CELL_WAIT,
      ST_SNAP_ADDR,
      ST_SNAP_CHECK
   } state_type;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [8:0]        cell_x;
      logic [8:0]        cell_y;
      logic signed [7:0] occupancy;
   } req_item_type;

   typedef struct packed {
      logic       blocked;
      logic [8:0] free_x;
      logic [8:0] free_y;
      logic       found;
   } rsp_item_type;

   typedef struct packed {
      logic         capture;
      logic         clr_start;
      logic         clr_step;
      logic         rd_cell;
      logic         ld_init;
      logic         ld_step;
      logic         snap_init;
      logic         snap_rd;
      logic         snap_next;
      logic         respond;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      req_kind_type req_kind;
      logic         in_map;
      logic         hit;
      logic         clr_last;
      logic         ld_last;
      logic         cell_bit;
      logic         cand_in;
      logic         cand_bit;
      logic         last_cand;
   } status_type;

endpackage

FILE: src/ogi_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ogi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: src/ogi_ctrl.sv
// Controller state machine: sequences clear, load, read and snap items.
`timescale 1ns / 1ps
module ogi_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  ogi_pkg::status_type sts,
   output ogi_pkg::cmd_type    cmd
);
   import ogi_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BOOT_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_kind = RSP_ZERO;
      case (state_ff)
         ST_BOOT_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (sts.req_kind)
               REQ_CLEAR: begin
                  cmd.clr_start = 1'b1;
                  state_in      = ST_CLEAR;
               end
               REQ_LOAD: begin
                  if (sts.in_map && sts.hit) begin
                     cmd.ld_init = 1'b1;
                     state_in    = ST_LOAD;
                  end else begin
                     cmd.respond = 1'b1;
                     state_in    = ST_IDLE;
                  end
               end
               REQ_READ: begin
                  if (sts.in_map) begin
                     cmd.rd_cell = 1'b1;
                     state_in    = ST_CELL_WAIT;
                  end else begin
                     cmd.respond  = 1'b1;
                     cmd.rsp_kind = RSP_READ;
                     state_in     = ST_IDLE;
                  end
               end
               default: begin
                  if (sts.in_map) begin
                     cmd.rd_cell = 1'b1;
                     state_in    = ST_CELL_WAIT;
                  end else begin
                     cmd.respond  = 1'b1;
                     cmd.rsp_kind = RSP_BLOCKED;
                     state_in     = ST_IDLE;
                  end
               end
            endcase
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_LOAD: begin
            // the last row write lands in the cycle after the last read
            cmd.ld_step = 1'b1;
            if (sts.ld_last) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_CELL_WAIT: begin
            if (sts.req_kind == REQ_READ) begin
               cmd.respond  = 1'b1;
               cmd.rsp_kind = RSP_READ;
               state_in     = ST_IDLE;
            end else if (!sts.cell_bit) begin
               cmd.respond  = 1'b1;
               cmd.rsp_kind = RSP_SELF;
               state_in     = ST_IDLE;
            end else begin
               cmd.snap_init = 1'b1;
               state_in      = ST_SNAP_ADDR;
            end
         end
         ST_SNAP_ADDR: begin
            if (sts.cand_in) begin
               cmd.snap_rd = 1'b1;
               state_in    = ST_SNAP_CHECK;
            end else if (sts.last_cand) begin
               cmd.respond  = 1'b1;
               cmd.rsp_kind = RSP_BLOCKED;
               state_in     = ST_IDLE;
            end else begin
               cmd.snap_next = 1'b1;
            end
         end
         ST_SNAP_CHECK: begin
            if (!sts.cand_bit) begin
               cmd.respond  = 1'b1;
               cmd.rsp_kind = RSP_FOUND;
               state_in     = ST_IDLE;
            end else if (sts.last_cand) begin
               cmd.respond  = 1'b1;
               cmd.rsp_kind = RSP_BLOCKED;
               state_in     = ST_IDLE;
            end else begin
               cmd.snap_next = 1'b1;
               state_in      = ST_SNAP_ADDR;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

FILE: src/ogi_dp.sv
// Datapath: settings, request registers, row memory, search counters and result.
`timescale 1ns / 1ps
module ogi_dp #(
   parameter int MAX_WIDTH    = ogi_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT   = ogi_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_RADIUS   = ogi_pkg::MAX_RADIUS_DEF,
   parameter int SEARCH_LIMIT = ogi_pkg::SEARCH_LIMIT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ogi_pkg::req_item_type req_data,
   input  logic                  csr_valid,
   input  logic [1:0]            csr_index,
   input  logic [9:0]            csr_wdata,
   input  ogi_pkg::cmd_type      cmd,
   output ogi_pkg::status_type   sts,
   output logic                  rsp_valid,
   output ogi_pkg::rsp_item_type rsp_data
);
   import ogi_pkg::*;

   localparam int XW      = $clog2(MAX_WIDTH);
   localparam int YW      = $clog2(MAX_HEIGHT);
   localparam int EW      = $clog2(MAX_WIDTH + 1);
   localparam int EH      = $clog2(MAX_HEIGHT + 1);
   localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int MAX_CRD = ((MAX_DIM > 512) ? MAX_DIM : 512) + SEARCH_LIMIT + MAX_RADIUS;
   localparam int CW      = $clog2(MAX_CRD + 1) + 1;
   localparam int SW      = $clog2(SEARCH_LIMIT + 1) + 1;

   logic [9:0] width_ff, height_ff;
   logic [3:0] radius_ff;
   logic [6:0] thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= MAP_WIDTH_RST;
         height_ff <= MAP_HEIGHT_RST;
         radius_ff <= RADIUS_RST;
         thresh_ff <= THRESHOLD_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_MAP_WIDTH:  width_ff  <= csr_wdata;
            CSR_MAP_HEIGHT: height_ff <= csr_wdata;
            CSR_RADIUS:     radius_ff <= csr_wdata[3:0];
            CSR_THRESHOLD:  thresh_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   logic [EW-1:0] eff_w;
   logic [EH-1:0] eff_h;
   logic signed [CW-1:0] rad;

   always_comb begin
      if (width_ff == '0) eff_w = EW'(1);
      else if (32'(width_ff) > 32'(MAX_WIDTH)) eff_w = EW'(MAX_WIDTH);
      else eff_w = EW'(width_ff);
      if (height_ff == '0) eff_h = EH'(1);
      else if (32'(height_ff) > 32'(MAX_HEIGHT)) eff_h = EH'(MAX_HEIGHT);
      else eff_h = EH'(height_ff);
      if (32'(radius_ff) > 32'(MAX_RADIUS)) rad = CW'(MAX_RADIUS);
      else rad = CW'(radius_ff);
   end

   req_item_type req_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   logic signed [CW-1:0] xs, ys, ws, hs;
   logic signed [CW-1:0] xl, xh, yl, yh, x0, x1, y0, y1;

   assign xs = $signed(CW'(req_ff.cell_x));
   assign ys = $signed(CW'(req_ff.cell_y));
   assign ws = $signed(CW'(eff_w));
   assign hs = $signed(CW'(eff_h));
   assign xl = xs - rad;
   assign xh = xs + rad;
   assign yl = ys - rad;
   assign yh = ys + rad;
   assign x0 = (xl < 0) ? '0 : xl;
   assign x1 = (xh > ws - CW'(1)) ? ws - CW'(1) : xh;
   assign y0 = (yl < 0) ? '0 : yl;
   assign y1 = (yh > hs - CW'(1)) ? hs - CW'(1) : yh;

   // Row memory
   logic [YW-1:0]        raddr, waddr;
   logic [MAX_WIDTH-1:0] rdata, wdata, mask_ff;
   logic                 we;

   logic [YW-1:0] clr_row_ff, clr_row_in;
   logic [YW-1:0] ld_row_ff, ld_end_ff, wr_row_ff;
   logic          wr_pend_ff;

   logic signed [SW-1:0] s_ff, i_ff, j_ff, s_in, i_in, j_in;
   logic signed [CW-1:0] cx, cy;

   assign cx = xs + CW'(i_ff);
   assign cy = ys + CW'(j_ff);

   always_comb begin
      if (cmd.clr_start) clr_row_in = '0;
      else if (cmd.clr_step) clr_row_in = clr_row_ff + YW'(1);
      else clr_row_in = clr_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_row_ff <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         clr_row_ff <= clr_row_in;
         wr_pend_ff <= cmd.ld_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_init) begin
         mask_ff   <= ({MAX_WIDTH{1'b1}} << x0[XW-1:0])
                    & ({MAX_WIDTH{1'b1}} >> (XW'(MAX_WIDTH - 1) - x1[XW-1:0]));
         ld_row_ff <= y0[YW-1:0];
         ld_end_ff <= y1[YW-1:0];
      end else if (cmd.ld_step) begin
         ld_row_ff <= ld_row_ff + YW'(1);
      end
      if (cmd.ld_step) begin
         wr_row_ff <= ld_row_ff;
      end
   end

   always_comb begin
      if (cmd.snap_rd) raddr = cy[YW-1:0];
      else if (cmd.rd_cell) raddr = req_ff.cell_y[YW-1:0];
      else raddr = ld_row_ff;
      we    = cmd.clr_step || wr_pend_ff;
      waddr = cmd.clr_step ? clr_row_ff : wr_row_ff;
      wdata = cmd.clr_step ? '0 : (rdata | mask_ff);
   end

   ogi_ram #(
      .WIDTH(MAX_WIDTH),
      .DEPTH(MAX_HEIGHT)
   ) u_map (
      .clock(clock),
      .we   (we),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(rdata)
   );

   // Perimeter walk of growing squares, column offset outer
   always_comb begin
      s_in = s_ff;
      i_in = i_ff;
      j_in = j_ff;
      if (cmd.snap_init) begin
         s_in = SW'(1);
         i_in = -SW'(1);
         j_in = -SW'(1);
      end else if (cmd.snap_next) begin
         if (j_ff == s_ff) begin
            if (i_ff == s_ff) begin
               s_in = s_ff + SW'(1);
               i_in = -(s_ff + SW'(1));
               j_in = -(s_ff + SW'(1));
            end else begin
               i_in = i_ff + SW'(1);
               j_in = -s_ff;
            end
         end else if (i_ff == s_ff || i_ff == -s_ff) begin
            j_in = j_ff + SW'(1);
         end else begin
            j_in = s_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
      i_ff <= i_in;
      j_ff <= j_in;
   end

   always_comb begin
      sts.req_kind  = req_kind_type'(req_ff.req_type);
      sts.in_map    = (xs < ws) && (ys < hs);
      sts.hit       = req_ff.occupancy > $signed({1'b0, thresh_ff});
      sts.clr_last  = (clr_row_ff == YW'(MAX_HEIGHT - 1));
      sts.ld_last   = (ld_row_ff == ld_end_ff);
      sts.cell_bit  = rdata[req_ff.cell_x[XW-1:0]];
      sts.cand_in   = (cx >= 0) && (cx < ws) && (cy >= 0) && (cy < hs);
      sts.cand_bit  = rdata[cx[XW-1:0]];
      sts.last_cand = (s_ff == SW'(SEARCH_LIMIT)) && (i_ff == s_ff) && (j_ff == s_ff);
   end

   // Result register
   logic         rsp_valid_ff;
   rsp_item_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in = '0;
      case (cmd.rsp_kind)
         RSP_READ: rsp_in.blocked = !sts.in_map || sts.cell_bit;
         RSP_SELF: begin
            rsp_in.free_x = req_ff.cell_x;
            rsp_in.free_y = req_ff.cell_y;
            rsp_in.found  = 1'b1;
         end
         RSP_BLOCKED: rsp_in.blocked = 1'b1;
         RSP_FOUND: begin
            rsp_in.blocked = 1'b1;
            rsp_in.free_x  = cx[8:0];
            rsp_in.free_y  = cy[8:0];
            rsp_in.found   = 1'b1;
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

FILE: src/occupancy_grid_inflation_unit.sv
// Top level of the occupancy grid inflation unit: controller plus datapath.
// Clear writes every row, load ORs the mask into the rows of the clipped square, and snap
// reads the cell, then each in-map candidate, until a free cell or the search limit.
// One item at a time; a new item can be accepted while the result is shown.
// The row memory (one MAX_WIDTH-bit row a cycle) sets the clear and load times.
// After reset a clearing pass over all MAX_HEIGHT rows runs with busy high.
`timescale 1ns / 1ps
module occupancy_grid_inflation_unit #(
   parameter int MAX_WIDTH    = ogi_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT   = ogi_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_RADIUS   = ogi_pkg::MAX_RADIUS_DEF,
   parameter int SEARCH_LIMIT = ogi_pkg::SEARCH_LIMIT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ogi_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   output ogi_pkg::rsp_item_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [9:0]            csr_wdata
);
   import ogi_pkg::*;

   cmd_type    cmd;
   status_type sts;

   assign csr_ready = 1'b1;

   ogi_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .sts  (sts),
      .cmd  (cmd)
   );

   ogi_dp #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .MAX_RADIUS  (MAX_RADIUS),
      .SEARCH_LIMIT(SEARCH_LIMIT)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_valid(csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held two cycles");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item left block idle");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without item in work");

   a_found_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.free_x == '0 && rsp_data.free_y == '0))
      else $error("coordinates reported without a free cell");
endmodule
